@@ sv/crc_checked_word_deframer_assert.svh @@
// assertion macros for the crc checked word deframer
// expects i_clk and i_rst_n in the scope of each use
`ifndef CRC_CHECKED_WORD_DEFRAMER_ASSERT_SVH
`define CRC_CHECKED_WORD_DEFRAMER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CCWD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// next-cycle implication, checked outside reset
`define CCWD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

@@ sv/ccwd_pkg.sv @@
// shared types and constants of the crc checked word deframer
// no dependencies
package ccwd_pkg;

    // crc-8 over the two data bytes
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // threshold reset values
    localparam logic [15:0] THR_GOOD_RST     = 16'd600;
    localparam logic [15:0] THR_MODERATE_RST = 16'd1000;
    localparam logic [15:0] THR_POOR_RST     = 16'd1500;
    localparam logic [15:0] THR_HAZARD_RST   = 16'd2500;

    // configuration register indexes
    localparam logic [1:0] CFG_THR_GOOD     = 2'd0;
    localparam logic [1:0] CFG_THR_MODERATE = 2'd1;
    localparam logic [1:0] CFG_THR_POOR     = 2'd2;
    localparam logic [1:0] CFG_THR_HAZARD   = 2'd3;

    // word index saturates here
    localparam logic [1:0] WORD_IDX_MAX = 2'd3;

    // quality levels
    localparam logic [2:0] LVL_EXCELLENT = 3'd0;
    localparam logic [2:0] LVL_GOOD      = 3'd1;
    localparam logic [2:0] LVL_MODERATE  = 3'd2;
    localparam logic [2:0] LVL_POOR      = 3'd3;
    localparam logic [2:0] LVL_HAZARD    = 3'd4;

    // position of a byte within its group of three
    typedef enum logic [1:0] {
        PH_HIGH = 2'd0,
        PH_LOW  = 2'd1,
        PH_CRC  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } t_rx_item;

    typedef struct packed {
        logic [15:0] received_word;
        logic [1:0]  word_index;
        logic        crc_good;
        logic        read_good;
        logic [2:0]  quality_level;
    } t_word_item;

    typedef struct packed {
        logic [15:0] good;
        logic [15:0] moderate;
        logic [15:0] poor;
        logic [15:0] hazard;
    } t_thresholds;

    // handshake between the top level and the deframer core
    typedef struct packed {
        logic step;   // core consumes the held byte this cycle
        logic emit;   // held byte closes a group and yields a word
    } t_core_ctl;

endpackage

@@ sv/ccwd_if.sv @@
// valid/ready channels for received bytes and decoded words
// depends on ccwd_pkg
interface ccwd_rx_if import ccwd_pkg::*; ();
    logic     valid;
    logic     ready;
    t_rx_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ccwd_word_if import ccwd_pkg::*; ();
    logic       valid;
    logic       ready;
    t_word_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/ccwd_crc8.sv @@
// one-byte update of crc-8, polynomial 0x31, msb first
// depends on ccwd_pkg
module ccwd_crc8 import ccwd_pkg::*; (
    input  logic [7:0] i_crc,
    input  logic [7:0] i_byte,
    output logic [7:0] o_crc
);

    // eight shift steps over the xor of crc and byte
    always_comb begin
        logic [7:0] v;
        v = i_crc ^ i_byte;
        for (int k = 0; k < 8; k++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        o_crc = v;
    end

endmodule

@@ sv/ccwd_grade.sv @@
// five-step quality level from a word and four thresholds
// depends on ccwd_pkg
module ccwd_grade import ccwd_pkg::*; (
    input  logic [15:0] i_word,
    input  t_thresholds i_thr,
    output logic [2:0]  o_level
);

    // first threshold that the word stays below decides
    always_comb begin
        if (i_word < i_thr.good) begin
            o_level = LVL_EXCELLENT;
        end else if (i_word < i_thr.moderate) begin
            o_level = LVL_GOOD;
        end else if (i_word < i_thr.poor) begin
            o_level = LVL_MODERATE;
        end else if (i_word < i_thr.hazard) begin
            o_level = LVL_POOR;
        end else begin
            o_level = LVL_HAZARD;
        end
    end

endmodule

@@ sv/ccwd_core.sv @@
// group tracking, crc check and word assembly for one held byte
// depends on ccwd_pkg, ccwd_crc8, ccwd_grade
module ccwd_core import ccwd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  t_rx_item    i_item,
    input  t_thresholds i_thr,
    output logic        o_emit,
    output t_word_item  o_word
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_crc, n_crc;
    logic [7:0]  r_high, n_high;
    logic [7:0]  r_low, n_low;
    logic [1:0]  r_wcount, n_wcount;
    logic        r_failed, n_failed;

    t_phase      phase_eff;
    logic [7:0]  crc_eff;
    logic [1:0]  wcount_eff;
    logic        failed_eff;
    logic [7:0]  crc_src;
    logic [7:0]  crc_upd;
    logic [15:0] word;
    logic        good;
    logic [2:0]  level;

    // a start byte restarts the read before it is taken as a high byte
    always_comb begin
        phase_eff  = i_item.frame_start ? PH_HIGH  : r_phase;
        crc_eff    = i_item.frame_start ? CRC_INIT : r_crc;
        wcount_eff = i_item.frame_start ? 2'd0     : r_wcount;
        failed_eff = i_item.frame_start ? 1'b0     : r_failed;
    end

    // high byte starts from the initial value, low byte continues
    assign crc_src = (phase_eff == PH_LOW) ? crc_eff : CRC_INIT;

    ccwd_crc8 u_crc8 (
        .i_crc  (crc_src),
        .i_byte (i_item.rx_byte),
        .o_crc  (crc_upd)
    );

    assign word = {r_high, r_low};
    assign good = (crc_eff == i_item.rx_byte);

    ccwd_grade u_grade (
        .i_word  (word),
        .i_thr   (i_thr),
        .o_level (level)
    );

    // next state per byte position
    always_comb begin
        n_phase  = phase_eff;
        n_crc    = crc_eff;
        n_high   = r_high;
        n_low    = r_low;
        n_wcount = wcount_eff;
        n_failed = failed_eff;
        case (phase_eff)
            PH_LOW: begin
                n_low   = i_item.rx_byte;
                n_crc   = crc_upd;
                n_phase = PH_CRC;
            end
            PH_CRC: begin
                n_crc    = CRC_INIT;
                n_phase  = PH_HIGH;
                n_failed = failed_eff | ~good;
                if (wcount_eff != WORD_IDX_MAX) begin
                    n_wcount = wcount_eff + 2'd1;
                end
            end
            default: begin
                n_high  = i_item.rx_byte;
                n_crc   = crc_upd;
                n_phase = PH_LOW;
            end
        endcase
    end

    // result fields for a closing crc byte
    always_comb begin
        o_emit               = (phase_eff == PH_CRC);
        o_word.received_word = word;
        o_word.word_index    = wcount_eff;
        o_word.crc_good      = good;
        o_word.read_good     = good & ~failed_eff;
        o_word.quality_level = level;
    end

    // state registers advance only when the byte is consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HIGH;
            r_crc    <= CRC_INIT;
            r_high   <= 8'd0;
            r_low    <= 8'd0;
            r_wcount <= 2'd0;
            r_failed <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_crc    <= n_crc;
            r_high   <= n_high;
            r_low    <= n_low;
            r_wcount <= n_wcount;
            r_failed <= n_failed;
        end
    end

endmodule

@@ sv/crc_checked_word_deframer.sv @@
// Deframer for sensor read responses. Bytes arrive on i_rx one item per cycle in
// groups of high data byte, low data byte and CRC-8 (poly 0x31, init 0xFF, msb
// first); frame_start on a byte opens a new read and drops any partial group. Every
// third byte yields one item on o_word with the 16-bit word, its index in the read
// (saturating at 3), the crc and sticky read-good flags, and a 0..4 quality level
// from the four threshold registers written through i_cfg_*. The block takes one
// byte every cycle while the output is not stalled; a byte is held in an input
// register, the one-byte crc update, crc check and threshold compares run on the
// held byte, and the word is registered in the output register when the byte is
// consumed. A stalled output only blocks bytes that close a group. Write thresholds
// while idle. Depends on ccwd_pkg, ccwd_if, ccwd_core and the assertion header.
`include "crc_checked_word_deframer_assert.svh"

module crc_checked_word_deframer import ccwd_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [15:0]    i_cfg_data,
    ccwd_rx_if.sink        i_rx,
    ccwd_word_if.source    o_word
);

    logic        r_in_valid;
    t_rx_item    r_in_item;
    logic        r_out_valid;
    t_word_item  r_out_item;
    t_thresholds r_thr;

    t_core_ctl   ctl;
    t_word_item  core_word;
    logic        out_free;
    logic        core_emit;

    // handshake between input register, core and output register
    assign out_free  = ~r_out_valid | o_word.ready;
    assign ctl.emit  = core_emit;
    assign ctl.step  = r_in_valid & (~ctl.emit | out_free);
    assign i_rx.ready = ~r_in_valid | ctl.step;

    assign o_word.valid = r_out_valid;
    assign o_word.data  = r_out_item;

    ccwd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (ctl.step),
        .i_item  (r_in_item),
        .i_thr   (r_thr),
        .o_emit  (core_emit),
        .o_word  (core_word)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_item <= i_rx.data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.step && ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_word.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.step && ctl.emit) begin
            r_out_item <= core_word;
        end
    end

    // threshold registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.good     <= THR_GOOD_RST;
            r_thr.moderate <= THR_MODERATE_RST;
            r_thr.poor     <= THR_POOR_RST;
            r_thr.hazard   <= THR_HAZARD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_THR_GOOD:     r_thr.good     <= i_cfg_data;
                CFG_THR_MODERATE: r_thr.moderate <= i_cfg_data;
                CFG_THR_POOR:     r_thr.poor     <= i_cfg_data;
                CFG_THR_HAZARD:   r_thr.hazard   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // a byte that closes no group never waits on the output side
    `CCWD_ASSERT_NOW(a_nonemit_flows, r_in_valid && !ctl.emit, ctl.step)
    // a consumed closing byte always lands in the output register
    `CCWD_ASSERT_NEXT(a_emit_lands, ctl.step && ctl.emit, r_out_valid)
    // read-good never claims a word whose own crc failed
    `CCWD_ASSERT_NOW(a_read_good_crc, r_out_valid && r_out_item.read_good, r_out_item.crc_good)

endmodule
